FILE: src/ifl_pkg.sv
// Shared types, constants and codes for the index free-list pool.
// No dependencies; every other file imports this package.
`default_nettype none

package ifl_pkg;

    localparam int POOL_DEPTH = 64;
    localparam int IDX_W      = 6;
    localparam int LINK_W     = 7;
    localparam int CNT_W      = 7;
    localparam int SIZE_W     = 7;

    localparam logic [LINK_W-1:0] LINK_NONE = '1;

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_AUDIT   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADIDX = 2'd2;
    localparam logic [1:0] ST_AUDIT  = 2'd3;

    typedef struct packed {
        logic              clear;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [LINK_W-1:0] wr_data;
        logic [IDX_W-1:0]  rd_addr;
    } ifl_ram_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] free_count;
        logic [1:0]       status;
        logic [IDX_W-1:0] slot_index;
    } ifl_result_t;

    function automatic logic [LINK_W-1:0] link_reset(input logic [IDX_W-1:0] addr);
        logic [LINK_W-1:0] val;
        if (addr == '0)
            val = LINK_NONE;
        else
            val = {1'b0, addr} - LINK_W'(1);
        return val;
    endfunction

endpackage

`default_nettype wire

FILE: src/ifl_link_ram.sv
// Next-link store of the free list with per-entry valid bits.
// Depends on ifl_pkg; an entry never written since a clear reads as its rebuild value.
`default_nettype none

module ifl_link_ram
    import ifl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ifl_ram_req_t       req,
    output logic [LINK_W-1:0]       rd_data
);

    logic [LINK_W-1:0]     mem [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] valid_reg;
    logic [LINK_W-1:0]     rd_data_reg;
    logic                  rd_valid_reg;
    logic [IDX_W-1:0]      rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg  <= mem[req.rd_addr];
        rd_valid_reg <= valid_reg[req.rd_addr];
        rd_addr_reg  <= req.rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clear)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : link_reset(rd_addr_reg);

endmodule

`default_nettype wire

FILE: src/ifl_seq.sv
// Request sequencer: head register, audit walker and one shared range compare.
// Depends on ifl_pkg; drives the link store and hands results to the output stage.
`default_nettype none

module ifl_seq
    import ifl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire logic [1:0]        opcode,
    input  wire logic [IDX_W-1:0]  release_index,
    input  wire logic [SIZE_W-1:0] size,
    input  wire logic              rebuild,
    input  wire logic [SIZE_W-1:0] rebuild_size,
    output ifl_ram_req_t           ram_req,
    input  wire logic [LINK_W-1:0] ram_rd_data,
    output logic                   res_valid,
    input  wire logic              res_take,
    output ifl_result_t            res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACQ,
        S_WALK,
        S_WALK_RD,
        S_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    ifl_result_t       res_reg, res_next;

    logic [LINK_W-1:0] cmp_val;
    logic              in_range;
    logic              accept;
    logic              walk_end;

    assign accept    = req_valid && (state_reg == S_IDLE);
    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;

    always_comb
    begin
        if (state_reg == S_IDLE)
            cmp_val = (opcode == OP_RELEASE) ? {1'b0, release_index} : head_reg;
        else
            cmp_val = cur_reg;
    end

    assign in_range = cmp_val < size;
    assign walk_end = !in_range || (count_reg == CNT_W'(size));

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        res_next   = res_reg;

        ram_req.clear   = rebuild;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = release_index;
        ram_req.wr_data = head_reg;
        ram_req.rd_addr = head_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next   = '0;
                    state_next = S_RESP;
                    case (opcode)
                        OP_ACQUIRE:
                        begin
                            if (in_range)
                                state_next = S_ACQ;
                            else
                                res_next.status = ST_EMPTY;
                        end
                        OP_RELEASE:
                        begin
                            if (in_range)
                            begin
                                ram_req.wr_en = 1'b1;
                                head_next     = {1'b0, release_index};
                            end
                            else
                            begin
                                res_next.status = ST_BADIDX;
                            end
                        end
                        OP_AUDIT:
                        begin
                            cur_next   = head_reg;
                            count_next = '0;
                            state_next = S_WALK;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_ACQ:
            begin
                res_next.slot_index = head_reg[IDX_W-1:0];
                head_next           = ram_rd_data;
                state_next          = S_RESP;
            end
            S_WALK:
            begin
                ram_req.rd_addr = cur_reg[IDX_W-1:0];
                if (walk_end)
                begin
                    res_next.free_count = count_reg;
                    if (cur_reg != LINK_NONE || count_reg != CNT_W'(size))
                        res_next.status = ST_AUDIT;
                    state_next = S_RESP;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                cur_next   = ram_rd_data;
                state_next = S_WALK;
            end
            S_RESP:
            begin
                if (res_take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rebuild)
            head_next = rebuild_size - LINK_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= LINK_W'(POOL_DEPTH - 1);
            cur_reg   <= '0;
            count_reg <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cur_reg   <= cur_next;
            count_reg <= count_next;
            res_reg   <= res_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/index_free_list_pool.sv
// Index free-list pool: acquire reads the head's link in S_ACQ; release and unused opcodes go
// straight to the response; audit alternates S_WALK and S_WALK_RD per slot walked (up to
// pool_size), as the one-read link store is revisited per step. One request is in work at
// a time; a finished result waits in the output register while the next request is taken.
// Reset, and any pool_size write, rebuild the list at once (all valid bits clear together).
// Depends on ifl_pkg, ifl_link_ram and ifl_seq.
`default_nettype none

module index_free_list_pool
    import ifl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // [1:0] opcode, [7:2] release_index
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,      // [5:0] slot_index, [7:6] status, [14:8] free_count
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data
);

    logic [SIZE_W-1:0] size_reg, size_next;
    logic              m_tvalid_reg;
    logic [15:0]       m_tdata_reg;

    ifl_ram_req_t      ram_req;
    logic [LINK_W-1:0] ram_rd_data;
    logic              res_valid;
    logic              res_take;
    ifl_result_t       res;

    always_comb
    begin
        if (cfg_wr_data == '0)
            size_next = SIZE_W'(1);
        else if (cfg_wr_data > SIZE_W'(POOL_DEPTH))
            size_next = SIZE_W'(POOL_DEPTH);
        else
            size_next = cfg_wr_data;
    end

    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg     <= SIZE_W'(POOL_DEPTH);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                size_reg <= size_next;
            if (res_take)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            m_tdata_reg <= {1'b0, res.free_count, res.status, res.slot_index};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    ifl_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (s_tvalid),
        .req_ready     (s_tready),
        .opcode        (s_tdata[1:0]),
        .release_index (s_tdata[7:2]),
        .size          (size_reg),
        .rebuild       (cfg_wr_en),
        .rebuild_size  (size_next),
        .ram_req       (ram_req),
        .ram_rd_data   (ram_rd_data),
        .res_valid     (res_valid),
        .res_take      (res_take),
        .res           (res)
    );

    ifl_link_ram u_link_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

FILE: tb/sv/index_free_list_pool_test.sv
// Self-checking testbench for index_free_list_pool: a directed table, then random traffic
// of acquire/release/audit/unused opcodes over several pool sizes, checked by a free-list
// predictor. Depends on ifl_pkg and the index_free_list_pool RTL.
`default_nettype none

module index_free_list_pool_test;
    import ifl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         DRAIN_CYCLES   = 2 * POOL_DEPTH + 12;
    localparam int         PLAN_ROWS      = 25;
    localparam int         PHASES         = 8;
    localparam int         PHASE_ITEMS    = 50;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [1:0]       op;
        logic [6:0]       arg;
        bit               typed;
        logic [IDX_W-1:0] slot;
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;       // [1:0] opcode, [7:2] release_index
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;       // [5:0] slot_index, [7:6] status, [14:8] free_count
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;

    int                pool_size;
    logic [LINK_W-1:0] free_head;
    logic [LINK_W-1:0] free_link [POOL_DEPTH];

    ifl_result_t       pending_results [$];
    logic [IDX_W-1:0]  held_slots [$];
    plan_row_t         plan [PLAN_ROWS];
    logic [6:0]        size_seq [6] = '{7'd8, 7'd1, 7'd64, 7'd3, 7'd127, 7'd0};

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int quiet_cycles;

    index_free_list_pool dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void rebuild_pool(input logic [6:0] value);
        if (value == 7'd0)
            pool_size = 1;
        else if (value > POOL_DEPTH)
            pool_size = POOL_DEPTH;
        else
            pool_size = value;
        for (int i = 0; i < POOL_DEPTH; i++)
            free_link[i] = (i == 0) ? LINK_NONE : LINK_W'(i - 1);
        free_head = LINK_W'(pool_size - 1);
    endfunction

    function automatic ifl_result_t pool_step(input logic [1:0] op, input logic [IDX_W-1:0] idx);
        ifl_result_t       res;
        logic [LINK_W-1:0] cur;
        int                walked;
        res = '0;
        case (op)
            OP_ACQUIRE:
            begin
                if (free_head == LINK_NONE || free_head >= pool_size)
                    res.status = ST_EMPTY;
                else
                begin
                    res.slot_index = free_head[IDX_W-1:0];
                    free_head      = free_link[free_head[IDX_W-1:0]];
                end
            end
            OP_RELEASE:
            begin
                if (idx >= pool_size)
                    res.status = ST_BADIDX;
                else
                begin
                    free_link[idx] = free_head;
                    free_head      = {1'b0, idx};
                end
            end
            OP_AUDIT:
            begin
                cur    = free_head;
                walked = 0;
                while (cur != LINK_NONE && walked < pool_size)
                begin
                    if (cur >= pool_size)
                        break;
                    walked++;
                    cur = free_link[cur[IDX_W-1:0]];
                end
                if (cur != LINK_NONE || walked != pool_size)
                    res.status = ST_AUDIT;
                res.free_count = CNT_W'(walked);
            end
            default:
                ;
        endcase
        return res;
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 17;
                recv_idle_pct = 88;
            end
            1:
            begin
                send_idle_pct = 88;
                recv_idle_pct = 17;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic send_request(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                                input bit typed, input ifl_result_t typed_res,
                                output ifl_result_t predicted);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {idx, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = pool_step(op, idx);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
    endtask

    task automatic write_pool_size(input logic [6:0] value);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        rebuild_pool(value);
        held_slots.delete();
    endtask

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        ifl_result_t got;
        ifl_result_t want;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata[14:0];
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: tdata %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.slot_index !== want.slot_index)
                begin
                    $error("slot_index mismatch: expected %0d, actual %0d",
                           want.slot_index, got.slot_index);
                    error_count++;
                end
                if (got.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                    error_count++;
                end
                if (got.free_count !== want.free_count)
                begin
                    $error("free_count mismatch: expected %0d, actual %0d",
                           want.free_count, got.free_count);
                    error_count++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL index_free_list_pool");
                $finish;
            end
        end
    end

    initial
    begin
        ifl_result_t      typed_res;
        ifl_result_t      got;
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        logic [6:0]       size_value;
        int               pick;
        int               roll;

        error_count  = 0;
        quiet_cycles = 0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        rst_n        = 1'b0;
        set_idling(0);
        rebuild_pool(7'd64);

        plan[0]  = '{ROW_REQ, OP_AUDIT,   7'd0,   1'b1, 6'd0,  ST_OK,     7'd64};
        plan[1]  = '{ROW_REQ, OP_ACQUIRE, 7'd0,   1'b1, 6'd63, ST_OK,     7'd0};
        plan[2]  = '{ROW_REQ, OP_RELEASE, 7'd63,  1'b0, 6'd0,  ST_OK,     7'd0};
        plan[3]  = '{ROW_REQ, OP_RELEASE, 7'd0,   1'b0, 6'd0,  ST_OK,     7'd0};
        plan[4]  = '{ROW_REQ, OP_AUDIT,   7'd0,   1'b0, 6'd0,  ST_OK,     7'd0};
        plan[5]  = '{ROW_REQ, OP_UNUSED,  7'd63,  1'b1, 6'd0,  ST_OK,     7'd0};
        plan[6]  = '{ROW_CFG, OP_ACQUIRE, 7'd0,   1'b0, 6'd0,  ST_OK,     7'd0};
        plan[7]  = '{ROW_REQ, OP_AUDIT,   7'd0,   1'b1, 6'd0,  ST_OK,     7'd1};
        plan[8]  = '{ROW_REQ, OP_ACQUIRE, 7'd0,   1'b1, 6'd0,  ST_OK,     7'd0};
        plan[9]  = '{ROW_REQ, OP_ACQUIRE, 7'd0,   1'b1, 6'd0,  ST_EMPTY,  7'd0};
        plan[10] = '{ROW_REQ, OP_AUDIT,   7'd0,   1'b0, 6'd0,  ST_OK,     7'd0};
        plan[11] = '{ROW_REQ, OP_RELEASE, 7'd1,   1'b1, 6'd0,  ST_BADIDX, 7'd0};
        plan[12] = '{ROW_REQ, OP_RELEASE, 7'd0,   1'b0, 6'd0,  ST_OK,     7'd0};
        plan[13] = '{ROW_CFG, OP_ACQUIRE, 7'd127, 1'b0, 6'd0,  ST_OK,     7'd0};
        plan[14] = '{ROW_REQ, OP_RELEASE, 7'd63,  1'b1, 6'd0,  ST_OK,     7'd0};
        plan[15] = '{ROW_REQ, OP_AUDIT,   7'd0,   1'b0, 6'd0,  ST_OK,     7'd0};
        plan[16] = '{ROW_CFG, OP_ACQUIRE, 7'd65,  1'b0, 6'd0,  ST_OK,     7'd0};
        plan[17] = '{ROW_REQ, OP_ACQUIRE, 7'd0,   1'b1, 6'd63, ST_OK,     7'd0};
        plan[18] = '{ROW_CFG, OP_ACQUIRE, 7'd2,   1'b0, 6'd0,  ST_OK,     7'd0};
        plan[19] = '{ROW_REQ, OP_RELEASE, 7'd2,   1'b1, 6'd0,  ST_BADIDX, 7'd0};
        plan[20] = '{ROW_REQ, OP_ACQUIRE, 7'd0,   1'b1, 6'd1,  ST_OK,     7'd0};
        plan[21] = '{ROW_REQ, OP_ACQUIRE, 7'd0,   1'b1, 6'd0,  ST_OK,     7'd0};
        plan[22] = '{ROW_REQ, OP_ACQUIRE, 7'd0,   1'b1, 6'd0,  ST_EMPTY,  7'd0};
        plan[23] = '{ROW_REQ, OP_RELEASE, 7'd1,   1'b0, 6'd0,  ST_OK,     7'd0};
        plan[24] = '{ROW_REQ, OP_AUDIT,   7'd0,   1'b0, 6'd0,  ST_OK,     7'd0};

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (plan[r].kind == ROW_CFG)
                write_pool_size(plan[r].arg);
            else
            begin
                typed_res.slot_index = plan[r].slot;
                typed_res.status     = plan[r].status;
                typed_res.free_count = plan[r].count;
                send_request(plan[r].op, plan[r].arg[IDX_W-1:0], plan[r].typed, typed_res, got);
            end
        end

        typed_res = '0;
        for (int p = 0; p < PHASES; p++)
        begin
            set_idling(p < 3 ? 0 : (p < 6 ? 1 : 2));
            if (p < 6)
                size_value = size_seq[p];
            else if (p == 6)
                size_value = 7'($urandom_range(2, 16));
            else
                size_value = 7'($urandom_range(17, 127));
            write_pool_size(size_value);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                idx  = IDX_W'($urandom_range(0, 63));
                if (roll < 40)
                    op = OP_ACQUIRE;
                else if (roll < 82)
                begin
                    op = OP_RELEASE;
                    if (roll < 72 && held_slots.size() != 0)
                    begin
                        pick = $urandom_range(0, held_slots.size() - 1);
                        idx  = held_slots[pick];
                        held_slots.delete(pick);
                    end
                end
                else if (roll < 95)
                    op = OP_AUDIT;
                else
                    op = OP_UNUSED;
                send_request(op, idx, 1'b0, typed_res, got);
                if (op == OP_ACQUIRE && got.status == ST_OK)
                    held_slots.insert(held_slots.size(), got.slot_index);
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS index_free_list_pool");
        else
            $display("FAIL index_free_list_pool");
        $finish;
    end

endmodule

`default_nettype wire
